@@ hdl/nbpd_pkg.sv @@
// ============================================================================
// nbpd_pkg - shared types and codes of the nearest-bin pick dispatcher
// Word layouts of both channels, command, status and register codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package nbpd_pkg;

  localparam int COUNT_W = 4;
  localparam int CODE_W  = 3;
  localparam int COORD_W = 4;
  localparam int DIST_W  = 9;

  // Commands carried by the input word.
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_LOAD    = 3'd1;
  localparam logic [2:0] CMD_REQUEST = 3'd2;
  localparam logic [2:0] CMD_RUN     = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  // Mover outcome codes.
  localparam logic [1:0] MOV_PENDING = 2'd0;
  localparam logic [1:0] MOV_SUCCESS = 2'd1;

  // Report codes of the output word.
  localparam logic [3:0] ST_NOTHING = 4'd0;
  localparam logic [3:0] ST_START   = 4'd1;
  localparam logic [3:0] ST_BUSY    = 4'd2;
  localparam logic [3:0] ST_QUEUED  = 4'd3;
  localparam logic [3:0] ST_FULL    = 4'd4;
  localparam logic [3:0] ST_MOVE    = 4'd5;
  localparam logic [3:0] ST_DONE    = 4'd6;
  localparam logic [3:0] ST_FAIL    = 4'd7;
  localparam logic [3:0] ST_NONE    = 4'd8;
  localparam logic [3:0] ST_GOERR   = 4'd9;
  localparam logic [3:0] ST_COUNT   = 4'd10;

  // Configuration register indexes.
  localparam logic CFG_GRID_COLS = 1'b0;
  localparam logic CFG_GRID_ROWS = 1'b1;

  typedef struct packed {
    logic [2:0]         command;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CODE_W-1:0]  item_code;
    logic [COUNT_W-1:0] count_value;
    logic               mover_busy;
    logic [1:0]         mover_result;
    logic               mover_accepts;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [CODE_W-1:0]  out_code;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [COUNT_W-1:0] out_count;
  } out_item_t;

endpackage

`default_nettype wire

@@ hdl/nbpd_if.sv @@
// ============================================================================
// nbpd_if - valid/ready channels of the nearest-bin pick dispatcher
// One interface for the command channel and one for the report channel.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface nbpd_in_if import nbpd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nbpd_out_if import nbpd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/nbpd_ram.sv @@
// ============================================================================
// nbpd_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nbpd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/nearest_bin_pick_dispatcher.sv @@
// ============================================================================
// nearest_bin_pick_dispatcher - grid item counts and pick request dispatch
// Counts per cell and item code, a pick request ring, nearest-cell search.
// ============================================================================
// Usage: commands arrive as words on in_i and every accepted word yields
// exactly one report word on out_o. in_i.ready is high only while the
// sequencer is idle; one command is handled at a time.
// Scan: a run step that dispatches reads the count RAM one cell per cycle
// over grid_cols * grid_rows cells while a single distance unit (square,
// add, compare) checks each cell.
// Reset and the start command both run a clearing pass over all
// ROWS_MAX * COLS_MAX * CODES count RAM entries, one entry per cycle;
// no command is taken meanwhile, register writes are. Registers reset to 8.
// Stall: a finished report sits in the output register until out_o.ready;
// the next command is taken while it waits, and its own report is held in
// the sequencer until the output register is free.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nearest_bin_pick_dispatcher import nbpd_pkg::*; #(
  parameter int COLS_MAX    = 8,
  parameter int ROWS_MAX    = 8,
  parameter int CODES       = 7,
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_COUNT   = 10
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [3:0] cfg_data_i,
  nbpd_in_if.sink         in_i,
  nbpd_out_if.source      out_o
);

  localparam int CellDepth = ROWS_MAX * COLS_MAX * CODES;
  localparam int CAW       = (CellDepth > 1) ? $clog2(CellDepth) : 1;
  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam logic [CAW-1:0] CellLast = CAW'(CellDepth - 1);
  localparam logic [PW-1:0]  QLast    = PW'(QUEUE_DEPTH - 1);
  localparam logic [4:0] ColsMax = 5'(COLS_MAX);
  localparam logic [4:0] RowsMax = 5'(ROWS_MAX);
  localparam logic [5:0] CodesN  = 6'(CODES);
  localparam logic [COUNT_W-1:0] MaxCnt = COUNT_W'(MAX_COUNT);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_POP, S_SCAN, S_DRAIN, S_DECIDE, S_DEC, S_FINISH
  } state_e;

  function automatic logic [CAW-1:0] cell_addr(input logic [CODE_W-1:0] code,
                                               input logic [COORD_W-1:0] r0,
                                               input logic [COORD_W-1:0] c0);
    int a;
    a = int'(code) * (ROWS_MAX * COLS_MAX) + int'(r0) * COLS_MAX + int'(c0);
    return CAW'(a);
  endfunction

  function automatic logic cell_ok(input logic [COORD_W-1:0] c,
                                   input logic [COORD_W-1:0] r,
                                   input logic [CODE_W-1:0] code);
    return (c != '0) && ({1'b0, c} <= ColsMax) && (r != '0) &&
           ({1'b0, r} <= RowsMax) && ({3'b0, code} < CodesN);
  endfunction

  state_e              state_q;
  logic [CAW-1:0]      clr_cnt_q;
  logic                clr_report_q;
  logic [3:0]          grid_cols_q, grid_rows_q;
  logic [PW-1:0]       head_q, tail_q;
  logic                move_active_q;
  logic [CODE_W-1:0]   active_code_q;
  logic [COORD_W-1:0]  active_col_q, active_row_q;
  in_item_t            it_q;
  out_item_t           res_q;
  out_item_t           out_q;
  logic                out_valid_q;
  logic [CODE_W-1:0]   scan_code_q;
  logic [COORD_W-1:0]  sc_q, sr_q;
  logic                p_valid_q;
  logic [COORD_W-1:0]  p_c_q, p_r_q;
  logic                found_q;
  logic [DIST_W-1:0]   best_q;
  logic [COORD_W-1:0]  best_c_q, best_r_q;

  // Count RAM and ring RAM ports.
  logic                cnt_we;
  logic [CAW-1:0]      cnt_waddr, cnt_raddr;
  logic [COUNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic                ring_we;
  logic [CODE_W-1:0]   ring_rdata;

  logic [3:0]          nc, nr;
  logic [PW-1:0]       head_next, tail_next;
  logic                in_cell_ok, it_cell_ok, in_code_ok, ring_code_ok;
  logic [CAW-1:0]      in_addr, act_addr;
  logic [COUNT_W-1:0]  load_val;
  logic [7:0]          sq_c, sq_r;
  logic [DIST_W-1:0]   sq_dist;
  logic                better;

  assign nc = ({1'b0, grid_cols_q} > ColsMax) ? ColsMax[3:0] : grid_cols_q;
  assign nr = ({1'b0, grid_rows_q} > RowsMax) ? RowsMax[3:0] : grid_rows_q;

  assign head_next = (head_q == QLast) ? '0 : PW'(head_q + 1'b1);
  assign tail_next = (tail_q == QLast) ? '0 : PW'(tail_q + 1'b1);

  assign in_cell_ok   = cell_ok(in_i.data.col, in_i.data.row, in_i.data.item_code);
  assign it_cell_ok   = cell_ok(it_q.col, it_q.row, it_q.item_code);
  assign in_code_ok   = {3'b0, in_i.data.item_code} < CodesN;
  assign ring_code_ok = {3'b0, ring_rdata} < CodesN;

  assign in_addr  = cell_addr(in_i.data.item_code, 4'(in_i.data.row - 4'd1),
                              4'(in_i.data.col - 4'd1));
  assign act_addr = cell_addr(active_code_q, 4'(active_row_q - 4'd1),
                              4'(active_col_q - 4'd1));
  assign load_val = (in_i.data.count_value > MaxCnt) ? MaxCnt : in_i.data.count_value;

  // Distance unit: squared distance of the cell in the read pipeline.
  assign sq_c    = {4'd0, p_c_q} * {4'd0, p_c_q};
  assign sq_r    = {4'd0, p_r_q} * {4'd0, p_r_q};
  assign sq_dist = {1'b0, sq_c} + {1'b0, sq_r};
  assign better  = p_valid_q && (cnt_rdata != '0) && (!found_q || (sq_dist < best_q));

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_cnt_q;
    cnt_wdata = '0;
    cnt_raddr = cell_addr(scan_code_q, sr_q, sc_q);
    unique case (state_q)
      S_CLEAR: begin
        cnt_we = 1'b1;
      end
      S_IDLE: begin
        cnt_we    = in_i.valid && (in_i.data.command == CMD_LOAD) && in_cell_ok;
        cnt_waddr = in_addr;
        cnt_wdata = load_val;
        cnt_raddr = (in_i.data.command == CMD_RUN) ? act_addr : in_addr;
      end
      S_DEC: begin
        // A success on a cell already at zero leaves it at zero.
        cnt_we    = 1'b1;
        cnt_waddr = act_addr;
        cnt_wdata = COUNT_W'(cnt_rdata - COUNT_W'(cnt_rdata != '0));
      end
      default: begin
      end
    endcase
  end

  assign ring_we = (state_q == S_IDLE) && in_i.valid &&
                   (in_i.data.command == CMD_REQUEST) && in_code_ok &&
                   (tail_next != head_q);

  nbpd_ram #(.WIDTH(COUNT_W), .DEPTH(CellDepth)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // The ring is always read at the head; the read data is registered, so it is current in the next cycle.
  nbpd_ram #(.WIDTH(CODE_W), .DEPTH(QUEUE_DEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (tail_q),
    .wdata_i (in_i.data.item_code),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_cnt_q     <= '0;
      clr_report_q  <= 1'b0;
      grid_cols_q   <= 4'd8;
      grid_rows_q   <= 4'd8;
      head_q        <= '0;
      tail_q        <= '0;
      move_active_q <= 1'b0;
      active_code_q <= '0;
      active_col_q  <= '0;
      active_row_q  <= '0;
      out_valid_q   <= 1'b0;
      p_valid_q     <= 1'b0;
      found_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_COLS: grid_cols_q <= cfg_data_i;
          CFG_GRID_ROWS: grid_rows_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      p_valid_q <= 1'b0;
      if (better) begin
        found_q  <= 1'b1;
        best_q   <= sq_dist;
        best_c_q <= p_c_q;
        best_r_q <= p_r_q;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= CAW'(clr_cnt_q + 1'b1);
          if (clr_cnt_q == CellLast) begin
            state_q <= clr_report_q ? S_FINISH : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_i.valid) begin
            it_q  <= in_i.data;
            res_q <= '{status: ST_NOTHING, default: '0};
            state_q <= S_FINISH;
            case (in_i.data.command)
              CMD_START: begin
                if (in_i.data.mover_busy) begin
                  res_q.status <= ST_BUSY;
                end else begin
                  head_q       <= '0;
                  tail_q       <= '0;
                  clr_cnt_q    <= '0;
                  clr_report_q <= 1'b1;
                  res_q.status <= ST_START;
                  state_q      <= S_CLEAR;
                end
              end
              CMD_REQUEST: begin
                if (in_code_ok) begin
                  res_q.out_code <= in_i.data.item_code;
                  if (tail_next == head_q) begin
                    res_q.status <= ST_FULL;
                  end else begin
                    tail_q       <= tail_next;
                    res_q.status <= ST_QUEUED;
                  end
                end
              end
              CMD_RUN: begin
                if (move_active_q) begin
                  if (in_i.data.mover_busy || in_i.data.mover_result == MOV_PENDING) begin
                    res_q.status <= ST_NOTHING;
                  end else if (in_i.data.mover_result == MOV_SUCCESS) begin
                    state_q <= S_DEC;
                  end else begin
                    // Any other outcome is a failure and drops the queue.
                    head_q        <= '0;
                    tail_q        <= '0;
                    move_active_q <= 1'b0;
                    res_q <= '{status: ST_FAIL, out_code: active_code_q,
                               out_col: active_col_q, out_row: active_row_q,
                               out_count: '0};
                  end
                end else if ((head_q != tail_q) && !in_i.data.mover_busy) begin
                  state_q <= S_POP;
                end
              end
              CMD_READ: begin
                state_q <= S_RD;
              end
              default: begin
              end
            endcase
          end
        end

        S_RD: begin
          res_q <= '{status: ST_COUNT, out_code: it_q.item_code, out_col: it_q.col,
                     out_row: it_q.row, out_count: it_cell_ok ? cnt_rdata : '0};
          state_q <= S_FINISH;
        end

        S_POP: begin
          head_q      <= head_next;
          scan_code_q <= ring_rdata;
          sc_q        <= '0;
          sr_q        <= '0;
          found_q     <= 1'b0;
          if (!ring_code_ok || nc == '0 || nr == '0) begin
            res_q   <= '{status: ST_NONE, out_code: ring_rdata, default: '0};
            state_q <= S_FINISH;
          end else begin
            state_q <= S_SCAN;
          end
        end

        S_SCAN: begin
          p_valid_q <= 1'b1;
          p_c_q     <= sc_q;
          p_r_q     <= sr_q;
          if (sc_q == 4'(nc - 4'd1)) begin
            sc_q <= '0;
            if (sr_q == 4'(nr - 4'd1)) begin
              state_q <= S_DRAIN;
            end else begin
              sr_q <= 4'(sr_q + 4'd1);
            end
          end else begin
            sc_q <= 4'(sc_q + 4'd1);
          end
        end

        S_DRAIN: begin
          state_q <= S_DECIDE;
        end

        S_DECIDE: begin
          state_q <= S_FINISH;
          if (!found_q) begin
            res_q <= '{status: ST_NONE, out_code: scan_code_q, default: '0};
          end else if (!it_q.mover_accepts) begin
            head_q <= '0;
            tail_q <= '0;
            res_q <= '{status: ST_GOERR, out_code: scan_code_q,
                       out_col: 4'(best_c_q + 4'd1), out_row: 4'(best_r_q + 4'd1),
                       out_count: '0};
          end else begin
            move_active_q <= 1'b1;
            active_code_q <= scan_code_q;
            active_col_q  <= 4'(best_c_q + 4'd1);
            active_row_q  <= 4'(best_r_q + 4'd1);
            res_q <= '{status: ST_MOVE, out_code: scan_code_q,
                       out_col: 4'(best_c_q + 4'd1), out_row: 4'(best_r_q + 4'd1),
                       out_count: '0};
          end
        end

        S_DEC: begin
          move_active_q <= 1'b0;
          res_q <= '{status: ST_DONE, out_code: active_code_q, out_col: active_col_q,
                     out_row: active_row_q, out_count: '0};
          state_q <= S_FINISH;
        end

        S_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The ring never takes a word that would make head and tail meet.
  a_ring_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> (tail_next != head_q))
    else $error("ring written while full");

  // A decrement only happens for a move that is in flight.
  a_dec_needs_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC) |-> move_active_q)
    else $error("count decrement without active move");

  // A report is only loaded on the way out of the finish state.
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FINISH))
    else $error("report loaded outside finish");

  // An accepted command always takes the sequencer out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("ready stayed high after accept");
`endif

endmodule

`default_nettype wire
